@@ src/wgm_pkg.sv @@
package wgm_pkg;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_VALUE  = 2'd2;
  localparam logic [1:0] ACT_END    = 2'd3;

  // pattern wildcards
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // one transaction moved into the store and the position tracker
  typedef struct packed {
    logic       fire;
    logic [1:0] action;
    logic [7:0] ch;
  } wgm_cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

@@ src/wgm_req_if.sv @@
interface wgm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] ch;

  modport source(output valid, output action, output ch, input ready);
  modport sink(input valid, input action, input ch, output ready);
endinterface

@@ src/wgm_rsp_if.sv @@
interface wgm_rsp_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source(output valid, output matched, output pattern_overflow, input ready);
  modport sink(input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ src/wildcard_glob_matcher.sv @@
// Channel  Dir  Payload                     Transaction
// req      in   action[1:0], ch[7:0]        valid & ready at clk rise
// rsp      out  matched, pattern_overflow   valid & ready at clk rise
//
// One transaction per cycle sustained. A request is held in the
// input register; the match set and pattern store update from there in a
// single step (log-depth star closure), and an end-of-value result is then
// written to the output register. Synchronous reset clears the length,
// overflow flag and both valid flags; the match set returns to start. Only
// end-of-value requests wait on a full output register; others pass freely.
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input logic            clk,
  input logic            rst,
  wgm_req_if.sink        req,
  wgm_rsp_if.source      rsp
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // input register
  logic       s1_valid;
  logic [1:0] s1_action;
  logic [7:0] s1_ch;
  logic       s1_go;
  logic       s1_is_end;

  // output register
  logic       out_valid;
  logic       out_matched;
  logic       out_ovf;

  wgm_pkg::wgm_cmd_t          cmd;
  logic [LEN_W-1:0]           length;
  logic                       overflow;
  logic [MAX_PATTERN-1:0]     en;
  logic [MAX_PATTERN-1:0]     star;
  logic [MAX_PATTERN-1:0]     qmark;
  logic [MAX_PATTERN-1:0][7:0] lit;
  logic                       hit;

  assign s1_is_end = (s1_action == wgm_pkg::ACT_END);
  // an end-of-value request needs a free output slot (or one being drained)
  assign s1_go     = s1_valid && (!s1_is_end || !out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_action <= req.action;
      s1_ch     <= req.ch;
    end
  end

  assign cmd.fire   = s1_go;
  assign cmd.action = s1_action;
  assign cmd.ch     = s1_ch;

  wgm_store #(.MAX_PATTERN(MAX_PATTERN)) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .length   (length),
    .overflow (overflow),
    .en       (en),
    .star     (star),
    .qmark    (qmark),
    .lit      (lit)
  );

  wgm_nfa #(.MAX_PATTERN(MAX_PATTERN)) u_nfa (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .length (length),
    .en     (en),
    .star   (star),
    .qmark  (qmark),
    .lit    (lit),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // overflow forces no match
  always_ff @(posedge clk) begin
    if (s1_go && s1_is_end) begin
      out_matched <= hit && !overflow;
      out_ovf     <= overflow;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.matched          = out_matched;
  assign rsp.pattern_overflow = out_ovf;

endmodule

@@ src/wgm_store.sv @@
module wgm_store #(
  parameter int MAX_PATTERN = 32,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wgm_pkg::wgm_cmd_t               cmd,
  output logic [LEN_W-1:0]                length,
  output logic                            overflow,
  output logic [MAX_PATTERN-1:0]          en,
  output logic [MAX_PATTERN-1:0]          star,
  output logic [MAX_PATTERN-1:0]          qmark,
  output logic [MAX_PATTERN-1:0][7:0]     lit
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic             has_room;
  logic             do_write;
  logic [IDX_W-1:0] widx;

  assign has_room = (length < LEN_W'(MAX_PATTERN));
  assign do_write = cmd.fire && (cmd.action == wgm_pkg::ACT_APPEND) && has_room;
  assign widx     = length[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (cmd.fire) begin
      case (cmd.action)
        wgm_pkg::ACT_CLEAR: begin
          length   <= '0;
          overflow <= 1'b0;
        end
        wgm_pkg::ACT_APPEND: begin
          if (has_room) begin
            length <= length + LEN_W'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entries held pre-decoded; case folded once on entry
  always_ff @(posedge clk) begin
    if (do_write) begin
      lit[widx]   <= wgm_pkg::fold_case(cmd.ch);
      star[widx]  <= (cmd.ch == wgm_pkg::CHAR_STAR);
      qmark[widx] <= (cmd.ch == wgm_pkg::CHAR_QMARK);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      en[i] = (LEN_W'(i) < length);
    end
  end

endmodule

@@ src/wgm_nfa.sv @@
module wgm_nfa #(
  parameter int MAX_PATTERN = 32,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wgm_pkg::wgm_cmd_t               cmd,
  input  logic [LEN_W-1:0]                length,
  input  logic [MAX_PATTERN-1:0]          en,
  input  logic [MAX_PATTERN-1:0]          star,
  input  logic [MAX_PATTERN-1:0]          qmark,
  input  logic [MAX_PATTERN-1:0][7:0]     lit,
  output logic                            hit
);

  localparam int N   = MAX_PATTERN + 1;
  localparam int LVL = $clog2(N);

  logic [N-1:0] active;
  logic [N-1:0] active_next;
  logic [N-1:0] gen [LVL+1];
  logic [N-1:0] prp [LVL+1];
  logic [N-1:0] cur;
  logic [N-1:0] nxt;
  logic [7:0]   vch;

  // star closure as a parallel prefix: c[j] = a[j] | (c[j-1] & star[j-1])
  always_comb begin
    gen[0] = active;
    prp[0] = {en & star, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j < N; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j] = gen[l][j] | (prp[l][j] & gen[l][j - (1 << l)]);
          prp[l+1][j] = prp[l][j] & prp[l][j - (1 << l)];
        end else begin
          gen[l+1][j] = gen[l][j];
          prp[l+1][j] = prp[l][j];
        end
      end
    end
    cur = gen[LVL];
  end

  assign hit = cur[length];
  assign vch = wgm_pkg::fold_case(cmd.ch);

  // one value byte: star holds its position, others advance on a match
  always_comb begin
    nxt = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cur[i] && en[i]) begin
        if (star[i]) begin
          nxt[i] = 1'b1;
        end else if (qmark[i] || lit[i] == vch) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    active_next = active;
    if (cmd.fire) begin
      case (cmd.action)
        wgm_pkg::ACT_VALUE: active_next = nxt;
        default:            active_next = N'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= N'(1);
    end else begin
      active <= active_next;
    end
  end

endmodule
